### rtl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared widths, default parameters, register indexes and opcodes.
// ----------------------------------------------------------------------------
package adsr_pkg;

   localparam int TIME_BITS_DEF  = 32;
   localparam int LEVEL_BITS_DEF = 16;

   localparam int LEN_BITS   = 24;
   localparam int INDEX_BITS = 3;

   localparam logic [LEN_BITS-1:0] ATTACK_RST  = 24'd4800;
   localparam logic [LEN_BITS-1:0] DECAY_RST   = 24'd480;
   localparam logic [LEN_BITS-1:0] RELEASE_RST = 24'd9600;
   localparam logic [LEN_BITS-1:0] SUSTAIN_RST = 24'd52429;
   localparam logic [LEN_BITS-1:0] PEAK_RST    = 24'd65535;
   localparam logic [LEN_BITS-1:0] FLOOR_RST   = 24'd7;

   typedef enum logic [INDEX_BITS-1:0] {
      REG_ATTACK  = 3'd0,
      REG_DECAY   = 3'd1,
      REG_RELEASE = 3'd2,
      REG_SUSTAIN = 3'd3,
      REG_PEAK    = 3'd4,
      REG_FLOOR   = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_NOTE_ON  = 2'd1,
      OP_NOTE_OFF = 2'd2
   } opcode_type;

endpackage

### rtl/adsr_csr.sv
// ----------------------------------------------------------------------------
// ADSR configuration registers
// Write-only register bank; lengths are presented with zero read as one.
// ----------------------------------------------------------------------------
module adsr_csr import adsr_pkg::*; #(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [INDEX_BITS-1:0] csr_index,
   input  logic [LEN_BITS-1:0]   csr_wdata,
   output logic [LEN_BITS-1:0]   attack_len,
   output logic [LEN_BITS-1:0]   decay_len,
   output logic [LEN_BITS-1:0]   release_len,
   output logic [LEVEL_BITS-1:0] sustain_level,
   output logic [LEVEL_BITS-1:0] peak_level,
   output logic [LEVEL_BITS-1:0] floor_level
);

   logic [LEN_BITS-1:0]   attack_ff, decay_ff, release_ff;
   logic [LEVEL_BITS-1:0] sustain_ff, peak_ff, floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= ATTACK_RST;
         decay_ff   <= DECAY_RST;
         release_ff <= RELEASE_RST;
         sustain_ff <= SUSTAIN_RST[LEVEL_BITS-1:0];
         peak_ff    <= PEAK_RST[LEVEL_BITS-1:0];
         floor_ff   <= FLOOR_RST[LEVEL_BITS-1:0];
      end else if (csr_we) begin
         case (csr_index)
            REG_ATTACK:  attack_ff  <= csr_wdata;
            REG_DECAY:   decay_ff   <= csr_wdata;
            REG_RELEASE: release_ff <= csr_wdata;
            REG_SUSTAIN: sustain_ff <= csr_wdata[LEVEL_BITS-1:0];
            REG_PEAK:    peak_ff    <= csr_wdata[LEVEL_BITS-1:0];
            REG_FLOOR:   floor_ff   <= csr_wdata[LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign attack_len    = (attack_ff  == '0) ? LEN_BITS'(1) : attack_ff;
   assign decay_len     = (decay_ff   == '0) ? LEN_BITS'(1) : decay_ff;
   assign release_len   = (release_ff == '0) ? LEN_BITS'(1) : release_ff;
   assign sustain_level = sustain_ff;
   assign peak_level    = peak_ff;
   assign floor_level   = floor_ff;

endmodule

### rtl/adsr_div.sv
// ----------------------------------------------------------------------------
// ADSR serial divider
// Restoring divider, one quotient bit per cycle; the quotient must fit in
// LEVEL_BITS, so the upper dividend bits start out below the divisor.
// ----------------------------------------------------------------------------
module adsr_div import adsr_pkg::*; #(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF,
   localparam int NUM_W = LEN_BITS + LEVEL_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_W-1:0]      dividend,
   input  logic [LEN_BITS-1:0]   divisor,
   output logic                  done,
   output logic [LEVEL_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(LEVEL_BITS + 1);

   logic [LEN_BITS-1:0]   rem_ff, rem_in;
   logic [LEVEL_BITS-1:0] low_ff, low_in;
   logic [LEN_BITS-1:0]   den_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  done_ff, done_in;
   logic [LEN_BITS:0]     trial;
   logic                  fits;

   assign trial = {rem_ff, low_ff[LEVEL_BITS-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in   = rem_ff;
      low_in   = low_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = dividend[NUM_W-1:LEVEL_BITS];
         low_in   = dividend[LEVEL_BITS-1:0];
         count_in = CNT_W'(LEVEL_BITS);
      end else if (count_ff != '0) begin
         if (fits) begin
            rem_in = LEN_BITS'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[LEN_BITS-1:0];
         end
         low_in   = {low_ff[LEVEL_BITS-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

### rtl/adsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// Linear ADSR envelope generator
// One voice: note-on/off requests stamp the time, tick requests return the
// envelope amplitude at the given time.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries requests: req_tuser is the opcode (tick, note on, note off),
//   req_tdata the sample time. rsp_* returns one amplitude per tick; note-on,
//   note-off and unknown opcodes return nothing. csr_* writes the lengths and
//   levels; the user must write only while no request is in progress, as the
//   block itself does not enforce it. A tick on a ramp runs through a shared
//   multiplier twice and a serial divider that retires one quotient bit per
//   cycle; a tick in sustain or past release skips both and goes straight
//   from the pick state to the output state.
//   req_tready is low while a tick is in progress.
//   The result sits in an output register; if the receiver stalls, the next
//   request is still taken, and a following tick waits before its result
//   is loaded.
//   Reset is synchronous: registers return to defaults, the gate is off with
//   both stamps at zero, and no response is pending.
// ----------------------------------------------------------------------------
module adsr_envelope_generator import adsr_pkg::*; #(
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int LEVEL_BITS = LEVEL_BITS_DEF,
   localparam int REQ_W = ((TIME_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((LEVEL_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // now_time
   input  logic [1:0]            req_tuser,   // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // amplitude
   input  logic                  csr_we,
   input  logic [INDEX_BITS-1:0] csr_index,
   input  logic [LEN_BITS-1:0]   csr_wdata
);

   localparam int NUM_W  = LEN_BITS + LEVEL_BITS;
   localparam int WIDE_W = (TIME_BITS > LEN_BITS) ? TIME_BITS : LEN_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SPLIT,
      S_PICK,
      S_MUL1,
      S_MUL2,
      S_START,
      S_DIV,
      S_OUT
   } state_type;

   logic [LEN_BITS-1:0]   attack_len, decay_len, release_len;
   logic [LEVEL_BITS-1:0] sustain_level, peak_level, floor_level;

   state_type             state_ff, state_in;
   logic                  gate_ff, gate_in;
   logic [TIME_BITS-1:0]  on_stamp_ff, on_stamp_in;
   logic [TIME_BITS-1:0]  off_stamp_ff, off_stamp_in;
   logic [WIDE_W-1:0]     elapsed_ff, elapsed_in;
   logic [WIDE_W-1:0]     diff_ff, diff_in;
   logic                  ramp_ff, ramp_in;
   logic [LEN_BITS-1:0]   opa_ff, opa_in, opa2_ff, opa2_in;
   logic [LEVEL_BITS-1:0] opb_ff, opb_in, opb2_ff, opb2_in;
   logic [LEN_BITS-1:0]   den_ff, den_in;
   logic [NUM_W-1:0]      acc_ff, acc_in;
   logic [LEVEL_BITS-1:0] amp_ff, amp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [TIME_BITS-1:0]  now_time;
   logic [TIME_BITS-1:0]  elapsed_raw;
   logic [NUM_W-1:0]      prod;
   logic [LEN_BITS-1:0]   len_sel;
   logic [LEN_BITS-1:0]   k_val;
   logic                  div_start, div_done;
   logic [LEVEL_BITS-1:0] div_quot;
   logic                  req_fire;

   adsr_csr #(.LEVEL_BITS(LEVEL_BITS)) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .attack_len    (attack_len),
      .decay_len     (decay_len),
      .release_len   (release_len),
      .sustain_level (sustain_level),
      .peak_level    (peak_level),
      .floor_level   (floor_level)
   );

   adsr_div #(.LEVEL_BITS(LEVEL_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign now_time    = req_tdata[TIME_BITS-1:0];
   assign elapsed_raw = now_time - (gate_ff ? on_stamp_ff : off_stamp_ff);
   assign req_tready  = (state_ff == S_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign prod        = opa_ff * opb_ff;
   assign len_sel     = gate_ff ? attack_len : release_len;
   assign k_val       = diff_ff[LEN_BITS-1:0];
   assign div_start   = (state_ff == S_START);

   always_comb begin
      state_in     = state_ff;
      gate_in      = gate_ff;
      on_stamp_in  = on_stamp_ff;
      off_stamp_in = off_stamp_ff;
      elapsed_in   = elapsed_ff;
      diff_in      = diff_ff;
      ramp_in      = ramp_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      opa2_in      = opa2_ff;
      opb2_in      = opb2_ff;
      den_in       = den_ff;
      acc_in       = acc_ff;
      amp_in       = amp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  OP_NOTE_ON: begin
                     on_stamp_in = now_time;
                     gate_in     = 1'b1;
                  end
                  OP_NOTE_OFF: begin
                     off_stamp_in = now_time;
                     gate_in      = 1'b0;
                  end
                  OP_TICK: begin
                     elapsed_in = WIDE_W'(elapsed_raw);
                     state_in   = S_SPLIT;
                  end
                  default: ;
               endcase
            end
         end
         S_SPLIT: begin
            diff_in = elapsed_ff - WIDE_W'(len_sel);
            ramp_in = gate_ff ? (elapsed_ff <= WIDE_W'(len_sel))
                              : (elapsed_ff <  WIDE_W'(len_sel));
            state_in = S_PICK;
         end
         S_PICK: begin
            opa2_in = '0;
            opb2_in = '0;
            state_in = S_MUL1;
            if (gate_ff && ramp_ff) begin
               opa_in = elapsed_ff[LEN_BITS-1:0];
               opb_in = peak_level;
               den_in = attack_len;
            end else if (gate_ff && diff_ff <= WIDE_W'(decay_len)) begin
               opa_in  = decay_len - k_val;
               opb_in  = peak_level;
               opa2_in = k_val;
               opb2_in = sustain_level;
               den_in  = decay_len;
            end else if (gate_ff) begin
               amp_in   = sustain_level;
               state_in = S_OUT;
            end else if (ramp_ff) begin
               opa_in = release_len - elapsed_ff[LEN_BITS-1:0];
               opb_in = sustain_level;
               den_in = release_len;
            end else begin
               amp_in   = '0;
               state_in = S_OUT;
            end
         end
         S_MUL1: begin
            acc_in   = prod;
            opa_in   = opa2_ff;
            opb_in   = opb2_ff;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            acc_in   = acc_ff + prod;
            state_in = S_START;
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               amp_in   = div_quot;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (amp_ff < floor_level) ? '0 : amp_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gate_ff      <= 1'b0;
         on_stamp_ff  <= '0;
         off_stamp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gate_ff      <= gate_in;
         on_stamp_ff  <= on_stamp_in;
         off_stamp_ff <= off_stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      elapsed_ff  <= elapsed_in;
      diff_ff     <= diff_in;
      ramp_ff     <= ramp_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      opa2_ff     <= opa2_in;
      opb2_ff     <= opb2_in;
      den_ff      <= den_in;
      acc_ff      <= acc_in;
      amp_ff      <= amp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule
